FILE: src/tftp_rr_pkg.sv
package tftp_rr_pkg;

	// Event codes carried by the action field.
	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_PACKET  = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	// What the engine asks the socket layer to transmit.
	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_RRQ  = 2'd1;
	localparam logic [1:0] SEND_ACK  = 2'd2;
	localparam logic [1:0] SEND_ERR  = 2'd3;

	// TFTP opcodes of interest.
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ERROR = 16'd5;
	localparam logic [15:0] OP_OACK  = 16'd6;

	localparam logic [15:0] WELL_KNOWN_PORT = 16'd69;
	localparam logic [11:0] HEADER_BYTES    = 12'd4;
	localparam logic [15:0] RX_BUFFER_BYTES = 16'd2048;
	localparam logic [1:0]  DALLY_ACKS      = 2'd3;

	// Configuration register indexes (word addresses on the APB port).
	localparam logic [1:0] REG_SERVER_ADDRESS     = 2'd0;
	localparam logic [1:0] REG_SERVER_PORT        = 2'd1;
	localparam logic [1:0] REG_RETRY_LIMIT        = 2'd2;
	localparam logic [1:0] REG_DEFAULT_BLOCK_SIZE = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_RUN    = 3'd1,
		PH_DALLY  = 3'd2,
		PH_OK     = 3'd3,
		PH_SRVERR = 3'd4,
		PH_NORESP = 3'd5,
		PH_WRFAIL = 3'd6
	} phase_t;

	typedef struct packed {
		logic [31:0] server_address;
		logic [15:0] server_port;
		logic [7:0]  retry_limit;
		logic [15:0] default_block_size;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] packet_length;
		logic [15:0] packet_opcode;
		logic [15:0] block_number;
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic        oack_has_size;
		logic [15:0] oack_size;
		logic        write_failed;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] next_block;
		logic [15:0] last_acked_block;
		logic [7:0]  retry_count;
		logic [15:0] block_size;
		logic [15:0] peer_port;
		logic [1:0]  dally_count;
	} state_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [15:0] send_block;
		logic        store_payload;
		logic [15:0] payload_bytes;
		logic        tid_rejected;
		phase_t      status;
	} result_t;

endpackage

FILE: src/tftp_rr_step.sv
module tftp_rr_step
	import tftp_rr_pkg::*;
(
	input  cfg_t    cfg,
	input  state_t  st,
	input  item_t   item,
	output state_t  ns,
	output result_t res
);

	logic [11:0] len_c;
	logic        hdr_ok;
	logic [15:0] payload_len;
	logic        capture;
	logic        src_ok;
	logic [15:0] prev_block;
	logic [1:0]  dally_next;

	// The receive buffer holds 2048 bytes; longer packets are seen as full buffers.
	assign len_c       = (item.packet_length > RX_BUFFER_BYTES) ? RX_BUFFER_BYTES[11:0]
	                                                            : item.packet_length[11:0];
	assign hdr_ok      = (len_c >= HEADER_BYTES);
	assign payload_len = {4'd0, len_c - HEADER_BYTES};
	assign capture     = (st.last_acked_block == 16'd0) &&
	                     ((st.peer_port == WELL_KNOWN_PORT) || (st.peer_port == 16'd0));
	assign src_ok      = capture || ((item.source_address == cfg.server_address) &&
	                                 (item.source_port == st.peer_port));
	assign prev_block  = st.next_block - 16'd1;
	assign dally_next  = st.dally_count + 2'd1;

	// Next protocol state.
	always_comb begin
		ns = st;
		if (item.action == ACT_START) begin
			ns.block_size       = cfg.default_block_size;
			ns.peer_port        = cfg.server_port;
			ns.next_block       = 16'd1;
			ns.last_acked_block = 16'd0;
			ns.retry_count      = 8'd0;
			ns.dally_count      = 2'd0;
			ns.phase            = PH_RUN;
		end else begin
			unique case (st.phase)
				PH_RUN: begin
					if (item.action == ACT_PACKET && hdr_ok) begin
						// The first reply fixes the server's transfer port.
						if (capture) begin
							ns.peer_port = item.source_port;
						end
						if (src_ok) begin
							if (item.packet_opcode == OP_OACK) begin
								if (item.oack_has_size) begin
									ns.block_size = item.oack_size;
								end
								ns.retry_count = 8'd0;
							end else if (item.packet_opcode == OP_DATA) begin
								if (item.block_number == st.next_block) begin
									if (item.write_failed) begin
										ns.phase = PH_WRFAIL;
									end else begin
										ns.last_acked_block = item.block_number;
										ns.retry_count      = 8'd0;
										// A short block is the last one of the file.
										if (payload_len < st.block_size) begin
											ns.phase       = PH_DALLY;
											ns.dally_count = 2'd0;
										end else begin
											ns.next_block = st.next_block + 16'd1;
										end
									end
								end
							end else if (item.packet_opcode == OP_ERROR) begin
								ns.phase = PH_SRVERR;
							end
						end
					end else if (item.action == ACT_TIMEOUT) begin
						if (st.retry_count >= cfg.retry_limit) begin
							ns.phase = PH_NORESP;
						end else begin
							ns.retry_count = st.retry_count + 8'd1;
						end
					end
				end
				PH_DALLY: begin
					if (item.action == ACT_PACKET && hdr_ok && item.packet_opcode == OP_DATA) begin
						ns.dally_count = dally_next;
						if (dally_next >= DALLY_ACKS) begin
							ns.phase = PH_OK;
						end
					end else if (item.action == ACT_PACKET || item.action == ACT_TIMEOUT) begin
						ns.phase = PH_OK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Reply to the event.
	always_comb begin
		res.send_kind     = SEND_NONE;
		res.send_block    = 16'd0;
		res.store_payload = 1'b0;
		res.payload_bytes = 16'd0;
		res.tid_rejected  = 1'b0;

		if (item.action == ACT_START) begin
			res.send_kind = SEND_RRQ;
		end else begin
			unique case (st.phase)
				PH_RUN: begin
					if (item.action == ACT_PACKET && hdr_ok) begin
						if (!src_ok) begin
							res.tid_rejected = 1'b1;
						end else if (item.packet_opcode == OP_OACK) begin
							res.send_kind = SEND_ACK;
						end else if (item.packet_opcode == OP_DATA) begin
							if (item.block_number == st.next_block) begin
								res.store_payload = 1'b1;
								res.payload_bytes = payload_len;
								if (item.write_failed) begin
									res.send_kind = SEND_ERR;
								end else begin
									res.send_kind  = SEND_ACK;
									res.send_block = item.block_number;
								end
							end else if (item.block_number == prev_block) begin
								res.send_kind  = SEND_ACK;
								res.send_block = item.block_number;
							end
						end
					end else if (item.action == ACT_TIMEOUT) begin
						if (st.retry_count < cfg.retry_limit) begin
							if (st.last_acked_block == 16'd0) begin
								res.send_kind = SEND_RRQ;
							end else begin
								res.send_kind  = SEND_ACK;
								res.send_block = st.last_acked_block;
							end
						end
					end
				end
				PH_DALLY: begin
					if (item.action == ACT_PACKET && hdr_ok && item.packet_opcode == OP_DATA) begin
						res.send_kind  = SEND_ACK;
						res.send_block = st.last_acked_block;
					end
				end
				default: begin
				end
			endcase
		end

		res.status = ns.phase;
	end

endmodule

FILE: src/tftp_read_receiver_core.sv
// An accepted event waits in the input register and moves into the result register when
// that register is empty or being drained; its result is taken from there.
// Throughput: one event per cycle unless the consumer stalls; the protocol state is updated
// in the same cycle that the event moves from the input register into the result register.
// Reset (arst_n low, asynchronous): both pipeline stages empty, phase idle, configuration
// registers at their documented defaults (port 69, 5 retries, 512-byte blocks).
module tftp_read_receiver_core
	import tftp_rr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// APB-style configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// Event channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [15:0] packet_length,
	input  logic [15:0] packet_opcode,
	input  logic [15:0] block_number,
	input  logic [31:0] source_address,
	input  logic [15:0] source_port,
	input  logic        oack_has_size,
	input  logic [15:0] oack_size,
	input  logic        write_failed,

	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  send_kind,
	output logic [15:0] send_block,
	output logic        store_payload,
	output logic [15:0] payload_bytes,
	output logic        tid_rejected,
	output logic [2:0]  status
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    cfg_write;

	// ------------------------------------------------------------------
	// Configuration registers. Software must write them only while the engine
	// is idle; the block neither enforces this nor interlocks the pipeline.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.server_address     <= 32'd0;
			cfg_q.server_port        <= WELL_KNOWN_PORT;
			cfg_q.retry_limit        <= 8'd5;
			cfg_q.default_block_size <= 16'd512;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_SERVER_ADDRESS:     cfg_q.server_address     <= pwdata;
				REG_SERVER_PORT:        cfg_q.server_port        <= pwdata[15:0];
				REG_RETRY_LIMIT:        cfg_q.retry_limit        <= pwdata[7:0];
				REG_DEFAULT_BLOCK_SIZE: cfg_q.default_block_size <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SERVER_ADDRESS:     prdata = cfg_q.server_address;
			REG_SERVER_PORT:        prdata = {16'd0, cfg_q.server_port};
			REG_RETRY_LIMIT:        prdata = {24'd0, cfg_q.retry_limit};
			REG_DEFAULT_BLOCK_SIZE: prdata = {16'd0, cfg_q.default_block_size};
			default:                prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// Stage 1: the accepted event is captured in the input register.
	// The stage moves on whenever the result register is empty or is being
	// drained, so the input side only stalls when both stages are full and
	// the consumer is stalling.
	// ------------------------------------------------------------------
	assign item_in.action         = action;
	assign item_in.packet_length  = packet_length;
	assign item_in.packet_opcode  = packet_opcode;
	assign item_in.block_number   = block_number;
	assign item_in.source_address = source_address;
	assign item_in.source_port    = source_port;
	assign item_in.oack_has_size  = oack_has_size;
	assign item_in.oack_size      = oack_size;
	assign item_in.write_failed   = write_failed;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	// ------------------------------------------------------------------
	// Protocol step: short compare/increment logic between the input
	// register and the result register. The state registers update only
	// when the event actually moves into the result register, so every
	// event sees the state left by the one before it.
	// ------------------------------------------------------------------
	tftp_rr_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.ns   (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase            <= PH_IDLE;
			state_q.next_block       <= 16'd1;
			state_q.last_acked_block <= 16'd0;
			state_q.retry_count      <= 8'd0;
			state_q.block_size       <= 16'd512;
			state_q.peer_port        <= WELL_KNOWN_PORT;
			state_q.dally_count      <= 2'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: result register. It holds a finished transaction until the
	// consumer takes it while stage 1 is already free to accept the next.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign send_kind     = res_s2.send_kind;
	assign send_block    = res_s2.send_block;
	assign store_payload = res_s2.store_payload;
	assign payload_bytes = res_s2.payload_bytes;
	assign tid_rejected  = res_s2.tid_rejected;
	assign status        = res_s2.status;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A stored payload is always answered with an ACK or an error packet.
	a_store_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.store_payload) |->
			(res_s2.send_kind == SEND_ACK || res_s2.send_kind == SEND_ERR))
		else $error("stored payload without ACK or error");

	// A packet dropped for a wrong source causes nothing else and keeps the transfer running.
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.tid_rejected) |->
			(res_s2.send_kind == SEND_NONE && !res_s2.store_payload &&
			 res_s2.status == PH_RUN))
		else $error("rejected packet produced output or changed phase");

	// A read request is only issued while the transfer is running and carries no block.
	a_rrq_running: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.send_kind == SEND_RRQ) |->
			(res_s2.status == PH_RUN && res_s2.send_block == 16'd0))
		else $error("read request outside the running phase");

	// The input side stalls only with both stages full, and then the stage 1 event holds.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 lost or changed an event while stalled");

endmodule

FILE: sim/tftp_read_receiver_core_test.sv
`timescale 1ns / 1ps

module tftp_read_receiver_core_test
	import tftp_rr_pkg::*;
();

	// Action code 3 has no meaning; the engine must ignore it.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// The slowest correct run is about 1800 events, each behind an input gap and an
	// output stall, which stays well under the cycle limit.
	localparam int CYCLE_LIMIT      = 1_500_000;
	localparam int RANDOM_PHASES    = 8;
	localparam int EVENTS_PER_PHASE = 225;

	// Scoreboard: keeps its own copy of the protocol state and the registers, works out
	// the reply of every accepted event and compares it with what the engine returns.
	class reply_scoreboard;
		cfg_t    regs;
		state_t  st;
		result_t expected_replies[$];
		int      mismatches;
		int      replies_checked;

		function new();
			regs.server_address     = '0;
			regs.server_port        = WELL_KNOWN_PORT;
			regs.retry_limit        = 8'd5;
			regs.default_block_size = 16'd512;
			st.phase            = PH_IDLE;
			st.next_block       = 16'd1;
			st.last_acked_block = '0;
			st.retry_count      = '0;
			st.block_size       = regs.default_block_size;
			st.peer_port        = regs.server_port;
			st.dally_count      = '0;
			mismatches      = 0;
			replies_checked = 0;
		endfunction

		function void write_register(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_SERVER_ADDRESS: regs.server_address = value;
				REG_SERVER_PORT: regs.server_port = value[15:0];
				REG_RETRY_LIMIT: regs.retry_limit = value[7:0];
				REG_DEFAULT_BLOCK_SIZE: regs.default_block_size = value[15:0];
				default: ;
			endcase
		endfunction

		// Until the first block is acked, a well-known or zero peer port lets any
		// source in and takes its port as the transfer port.
		function bit source_accepted(logic [31:0] addr, logic [15:0] port);
			if (st.last_acked_block == '0 &&
					(st.peer_port == WELL_KNOWN_PORT || st.peer_port == '0)) begin
				st.peer_port = port;
				return 1'b1;
			end
			return addr == regs.server_address && port == st.peer_port;
		endfunction

		function void predict_reply(item_t ev);
			result_t     r;
			logic [15:0] len;
			logic [15:0] payload_len;
			r = '0;
			len = (ev.packet_length > RX_BUFFER_BYTES) ? RX_BUFFER_BYTES : ev.packet_length;
			if (ev.action == ACT_START) begin
				st.block_size       = regs.default_block_size;
				st.peer_port        = regs.server_port;
				st.next_block       = 16'd1;
				st.last_acked_block = '0;
				st.retry_count      = '0;
				st.dally_count      = '0;
				st.phase            = PH_RUN;
				r.send_kind         = SEND_RRQ;
			end else if (st.phase == PH_RUN) begin
				if (ev.action == ACT_PACKET && len >= 16'(HEADER_BYTES)) begin
					if (!source_accepted(ev.source_address, ev.source_port)) begin
						r.tid_rejected = 1'b1;
					end else if (ev.packet_opcode == OP_OACK) begin
						if (ev.oack_has_size)
							st.block_size = ev.oack_size;
						r.send_kind    = SEND_ACK;
						st.retry_count = '0;
					end else if (ev.packet_opcode == OP_DATA) begin
						if (ev.block_number == st.next_block) begin
							payload_len = len - 16'(HEADER_BYTES);
							r.store_payload = 1'b1;
							r.payload_bytes = payload_len;
							if (ev.write_failed) begin
								r.send_kind = SEND_ERR;
								st.phase    = PH_WRFAIL;
							end else begin
								r.send_kind         = SEND_ACK;
								r.send_block        = ev.block_number;
								st.last_acked_block = ev.block_number;
								st.retry_count      = '0;
								if (payload_len < st.block_size) begin
									st.phase       = PH_DALLY;
									st.dally_count = '0;
								end else begin
									st.next_block = st.next_block + 16'd1;
								end
							end
						end else if (ev.block_number == st.next_block - 16'd1) begin
							r.send_kind  = SEND_ACK;
							r.send_block = ev.block_number;
						end
					end else if (ev.packet_opcode == OP_ERROR) begin
						st.phase = PH_SRVERR;
					end
				end else if (ev.action == ACT_TIMEOUT) begin
					if (st.retry_count >= regs.retry_limit) begin
						st.phase = PH_NORESP;
					end else begin
						st.retry_count = st.retry_count + 8'd1;
						if (st.last_acked_block == '0) begin
							r.send_kind = SEND_RRQ;
						end else begin
							r.send_kind  = SEND_ACK;
							r.send_block = st.last_acked_block;
						end
					end
				end
			end else if (st.phase == PH_DALLY) begin
				if (ev.action == ACT_PACKET && len >= 16'(HEADER_BYTES) &&
						ev.packet_opcode == OP_DATA) begin
					r.send_kind    = SEND_ACK;
					r.send_block   = st.last_acked_block;
					st.dally_count = st.dally_count + 2'd1;
					if (st.dally_count >= DALLY_ACKS)
						st.phase = PH_OK;
				end else if (ev.action == ACT_PACKET || ev.action == ACT_TIMEOUT) begin
					st.phase = PH_OK;
				end
			end
			r.status = st.phase;
			expected_replies.push_back(r);
		endfunction

		task report(string msg);
			$display("MISMATCH at reply %0d: %s", replies_checked, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_reply(result_t got);
			result_t want;
			if (expected_replies.size() == 0) begin
				report("reply with no event waiting for one");
				return;
			end
			want = expected_replies.pop_front();
			compare_field("send_kind", 32'(got.send_kind), 32'(want.send_kind));
			compare_field("send_block", 32'(got.send_block), 32'(want.send_block));
			compare_field("store_payload", 32'(got.store_payload), 32'(want.store_payload));
			compare_field("payload_bytes", 32'(got.payload_bytes), 32'(want.payload_bytes));
			compare_field("tid_rejected", 32'(got.tid_rejected), 32'(want.tid_rejected));
			compare_field("status", 32'(got.status), 32'(want.status));
			replies_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = '0;
	logic [15:0] packet_length = '0;
	logic [15:0] packet_opcode = '0;
	logic [15:0] block_number = '0;
	logic [31:0] source_address = '0;
	logic [15:0] source_port = '0;
	logic        oack_has_size = 1'b0;
	logic [15:0] oack_size = '0;
	logic        write_failed = 1'b0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  send_kind;
	logic [15:0] send_block;
	logic        store_payload;
	logic [15:0] payload_bytes;
	logic        tid_rejected;
	logic [2:0]  status;

	reply_scoreboard sb;

	// When set, neither side idles, so transactions move back to back.
	bit          no_idle = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;
	// Source port the simulated server answers from on the next transfer.
	logic [15:0] xfer_port = 16'd1069;
	// Remaining timeouts in a burst that models a silent server.
	int          timeouts_left = 0;

	tftp_read_receiver_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.packet_length (packet_length),
		.packet_opcode (packet_opcode),
		.block_number  (block_number),
		.source_address(source_address),
		.source_port   (source_port),
		.oack_has_size (oack_has_size),
		.oack_size     (oack_size),
		.write_failed  (write_failed),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.send_kind     (send_kind),
		.send_block    (send_block),
		.store_payload (store_payload),
		.payload_bytes (payload_bytes),
		.tid_rejected  (tid_rejected),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Idle stretches: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The result side stalls in random runs. Stall only changes on the falling edge, so
	// it is stable when the rising edge samples it.
	always @(negedge clk) begin
		if (no_idle) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 99) < 30) begin
			out_stall <= 1'b1;
			stall_left = idle_len();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// A reply transaction completes at a rising edge with valid high and stall low. The
	// outputs are read before the edge's register updates land.
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.send_kind     = send_kind;
			got.send_block    = send_block;
			got.store_payload = store_payload;
			got.payload_bytes = payload_bytes;
			got.tid_rejected  = tid_rejected;
			got.status        = phase_t'(status);
			sb.check_reply(got);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	function automatic item_t pkt(logic [1:0] act, logic [15:0] len, logic [15:0] op,
			logic [15:0] blk, logic [31:0] addr, logic [15:0] port, logic has,
			logic [15:0] size, logic wf);
		item_t ev;
		ev.action         = act;
		ev.packet_length  = len;
		ev.packet_opcode  = op;
		ev.block_number   = blk;
		ev.source_address = addr;
		ev.source_port    = port;
		ev.oack_has_size  = has;
		ev.oack_size      = size;
		ev.write_failed   = wf;
		return ev;
	endfunction

	// An event of the given action with every other field random.
	function automatic item_t scrambled(logic [1:0] act);
		return pkt(act, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
	endfunction

	// Port the server answers from: the new transfer port while capture is still
	// open, the captured or configured port afterwards.
	function automatic logic [15:0] reply_port();
		if (sb.st.last_acked_block == '0 &&
				(sb.st.peer_port == WELL_KNOWN_PORT || sb.st.peer_port == '0))
			return xfer_port;
		return sb.st.peer_port;
	endfunction

	// Length of a DATA packet that carries a full block. When the block size is
	// beyond what the receive buffer holds, every block is short.
	function automatic logic [15:0] full_length();
		logic [15:0] bs;
		bs = sb.st.block_size;
		if (bs > 16'd2044)
			return 16'($urandom_range(4, 2048));
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(bs + 4, 65535));
		return bs + 16'd4;
	endfunction

	function automatic logic [15:0] short_length();
		logic [15:0] bs;
		bs = sb.st.block_size;
		if (bs == '0)
			return 16'd4;
		return 16'($urandom_range(4, (bs > 16'd2044) ? 2048 : bs + 3));
	endfunction

	function automatic item_t proper_data(logic [15:0] blk, logic [15:0] len, logic wf);
		item_t ev;
		ev = scrambled(ACT_PACKET);
		ev.packet_length  = len;
		ev.packet_opcode  = OP_DATA;
		ev.block_number   = blk;
		ev.source_address = sb.regs.server_address;
		ev.source_port    = reply_port();
		ev.write_failed   = wf;
		return ev;
	endfunction

	// A start also picks the port the server will answer from, now and then one of the
	// values that keep capture open.
	function automatic item_t start_event();
		case ($urandom_range(0, 9))
			0: xfer_port = WELL_KNOWN_PORT;
			1: xfer_port = '0;
			default: xfer_port = 16'($urandom_range(1024, 65535));
		endcase
		return scrambled(ACT_START);
	endfunction

	function automatic item_t noise_event();
		item_t ev;
		ev = scrambled(($urandom_range(0, 7) == 0) ? 2'($urandom) : ACT_PACKET);
		case ($urandom_range(0, 3))
			0: ev.packet_opcode = OP_DATA;
			1: ev.packet_opcode = OP_ERROR;
			2: ev.packet_opcode = OP_OACK;
			default: ;
		endcase
		return ev;
	endfunction

	// Next random event. While a transfer runs, most events are what a well-behaved
	// server sends; the rest are retransmissions, wrong sources, timeouts and junk.
	function automatic item_t next_event();
		item_t       ev;
		item_t       nz;
		int          r;
		logic [15:0] eb;
		r = $urandom_range(0, 99);
		eb = sb.st.next_block;
		if (sb.st.phase != PH_RUN)
			timeouts_left = 0;
		case (sb.st.phase)
			PH_RUN: begin
				if (timeouts_left > 0) begin
					timeouts_left--;
					return scrambled(ACT_TIMEOUT);
				end
				if (r < 2)
					return start_event();
				if (r < 52)
					return proper_data(eb,
						($urandom_range(0, 11) == 0) ? short_length() : full_length(),
						$urandom_range(0, 99) < 4);
				if (r < 60)
					return proper_data(eb - 16'd1, full_length(), 1'($urandom));
				if (r < 66) begin
					ev = proper_data(16'($urandom), 16'($urandom_range(4, 600)), 1'($urandom));
					ev.packet_opcode = OP_OACK;
					ev.oack_has_size = $urandom_range(0, 4) != 0;
					ev.oack_size = ($urandom_range(0, 2) == 0) ? 16'($urandom)
						: 16'($urandom_range(8, 600));
					return ev;
				end
				if (r < 74) begin
					if ($urandom_range(0, 4) == 0)
						timeouts_left = $urandom_range(1, 8);
					return scrambled(ACT_TIMEOUT);
				end
				if (r < 76) begin
					ev = proper_data(16'($urandom), full_length(), 1'($urandom));
					ev.packet_opcode = OP_ERROR;
					return ev;
				end
				if (r < 85) begin
					ev = proper_data(eb, full_length(), 1'b0);
					if ($urandom_range(0, 1))
						ev.source_address = $urandom;
					else
						ev.source_port = 16'($urandom);
					return ev;
				end
				if (r < 89) begin
					ev = proper_data(eb, 16'($urandom_range(0, 3)), 1'($urandom));
					nz = noise_event();
					ev.packet_opcode = nz.packet_opcode;
					return ev;
				end
				if (r < 95) begin
					ev = proper_data(eb, full_length(), 1'($urandom));
					if ($urandom_range(0, 1))
						ev.packet_opcode = 16'($urandom);
					else
						ev.block_number = 16'($urandom);
					return ev;
				end
				if (r < 97)
					return scrambled(ACT_UNUSED);
				return noise_event();
			end
			PH_DALLY: begin
				if (r < 55) begin
					ev = scrambled(ACT_PACKET);
					ev.packet_opcode = OP_DATA;
					ev.packet_length = 16'($urandom_range(4, 2048));
					return ev;
				end
				if (r < 65)
					return scrambled(ACT_TIMEOUT);
				if (r < 75) begin
					ev = noise_event();
					ev.action = ACT_PACKET;
					ev.packet_length = 16'($urandom_range(0, 3));
					return ev;
				end
				if (r < 85) begin
					ev = scrambled(ACT_PACKET);
					ev.packet_length = 16'($urandom_range(4, 2048));
					ev.packet_opcode = ($urandom_range(0, 1)) ? OP_OACK : OP_ERROR;
					return ev;
				end
				if (r < 90)
					return start_event();
				return noise_event();
			end
			default: begin
				if (r < 75)
					return start_event();
				if (r < 85)
					return scrambled(ACT_TIMEOUT);
				return noise_event();
			end
		endcase
	endfunction

	// Offers one event transaction, holding it until the engine takes it. Called and
	// left just after a falling edge.
	task automatic send_event(item_t ev);
		int gap;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action         <= ev.action;
		packet_length  <= ev.packet_length;
		packet_opcode  <= ev.packet_opcode;
		block_number   <= ev.block_number;
		source_address <= ev.source_address;
		source_port    <= ev.source_port;
		oack_has_size  <= ev.oack_has_size;
		oack_size      <= ev.oack_size;
		write_failed   <= ev.write_failed;
		in_valid       <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.predict_reply(ev);
		@(negedge clk);
	endtask

	// Stops offering events and waits until every reply is back, so that the engine is
	// idle and registers may be written.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.write_register(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(logic [31:0] addr, logic [15:0] port, logic [7:0] retries,
			logic [15:0] bsize);
		write_register(REG_SERVER_ADDRESS, addr);
		write_register(REG_SERVER_PORT, {16'd0, port});
		write_register(REG_RETRY_LIMIT, {24'd0, retries});
		write_register(REG_DEFAULT_BLOCK_SIZE, {16'd0, bsize});
	endtask

	// The first phases take the extremes of the registers; later ones are random, with
	// small block sizes most of the time so that transfers run over many blocks.
	task automatic choose_settings(int p);
		logic [31:0] addr;
		logic [15:0] port;
		logic [7:0]  retries;
		logic [15:0] bsize;
		addr = $urandom;
		case ($urandom_range(0, 4))
			0, 1: port = WELL_KNOWN_PORT;
			2: port = '0;
			default: port = 16'($urandom);
		endcase
		retries = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
		bsize = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(8, 65464))
			: 16'($urandom_range(8, 600));
		if (p == 0) begin
			addr = 32'hFFFF_FFFF;
			retries = 8'd0;
			bsize = 16'd8;
		end
		if (p == 1) begin
			addr = '0;
			port = '0;
			retries = 8'd255;
			bsize = 16'd65464;
		end
		if (p == 2)
			port = 16'hFFFF;
		apply_settings(addr, port, retries, bsize);
	endtask

	initial begin : stimulus
		item_t       script[$];
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, run with the registers at their reset values (server address 0,
		// port 69, five retries, 512-byte blocks).
		// Events before any start are ignored, and so is the unused action code.
		script.push_back(pkt(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 100, OP_DATA, 1, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_UNUSED, 100, OP_DATA, 1, 0, 1234, 0, 0, 0));
		// Start, a packet too short to hold a header, and a timeout that resends the request.
		script.push_back(pkt(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 3, OP_DATA, 1, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));
		// The OACK captures port 1234 from any address and sets 16-byte blocks.
		script.push_back(pkt(ACT_PACKET, 30, OP_OACK, 0, 32'hDEAD_BEEF, 1234, 1, 16, 0));
		// Wrong port, then wrong address: both dropped as foreign.
		script.push_back(pkt(ACT_PACKET, 20, OP_DATA, 1, 0, 1235, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 20, OP_DATA, 1, 32'h1, 1234, 0, 0, 0));
		// Full block 1, its duplicate, an unknown opcode and an out-of-order block.
		script.push_back(pkt(ACT_PACKET, 20, OP_DATA, 1, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 20, OP_DATA, 1, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 20, 16'hFFFF, 2, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 20, OP_DATA, 7, 0, 1234, 0, 0, 0));
		// A timeout now resends the last ACK.
		script.push_back(pkt(ACT_TIMEOUT, 0, 0, 0, 0, 0, 0, 0, 0));
		// An oversized packet is cut to the receive buffer; then a short block ends it.
		script.push_back(pkt(ACT_PACKET, 16'hFFFF, OP_DATA, 2, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 10, OP_DATA, 3, 0, 1234, 0, 0, 0));
		// Dally: three stray DATA packets from anywhere are acked, the third ends it.
		script.push_back(pkt(ACT_PACKET, 10, OP_DATA, 9, 32'h5, 7, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 10, OP_DATA, 3, 0, 1234, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 2048, OP_DATA, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
			16'hFFFF, 1));
		// New transfer: the first DATA fails to store, so an ERROR goes out.
		script.push_back(pkt(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 16'hFFFF, OP_DATA, 1, 32'hFFFF_FFFF, 16'hFFFF, 1,
			16'hFFFF, 1));
		// New transfer ended by a server ERROR.
		script.push_back(pkt(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 4, OP_ERROR, 0, 0, 4000, 0, 0, 0));
		// New transfer: an OACK with block size zero makes every block full.
		script.push_back(pkt(ACT_START, 0, 0, 0, 0, 0, 0, 0, 0));
		script.push_back(pkt(ACT_PACKET, 12, OP_OACK, 0, 0, 4000, 1, 0, 0));
		script.push_back(pkt(ACT_PACKET, 4, OP_DATA, 1, 0, 4000, 0, 0, 0));
		foreach (script[i])
			send_event(script[i]);
		drain();

		// Random phases, each under its own register settings.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			choose_settings(p);
			for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
				if (n % 64 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_event(next_event());
			end
			drain();
		end
		repeat (20) @(posedge clk);

		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
